// ----- src/psl_pkg.sv -----
`default_nettype none

package psl_pkg;

    // Word width of one list entry
    localparam int WORD_W = 32;
    // Width of the one-based position and of the reported lengths
    localparam int POS_W  = 7;

    // Request codes carried in the func field
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    // Command broadcast from the controller to every cell of the row
    typedef struct packed {
        logic              ins;      // insert at pos_idx, shift later entries up
        logic              del;      // delete at pos_idx, shift later entries down
        logic [POS_W-1:0]  pos_idx;  // zero-based target index
        logic [WORD_W-1:0] word;     // word to insert or value to search for
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/psl_cell.sv -----
`default_nettype none

module psl_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                      aclk,
    input  wire psl_pkg::cmd_t             ctl,
    input  wire logic                      live,       // this entry is inside the list
    input  wire logic [psl_pkg::WORD_W-1:0] left_val,  // entry of the cell below
    input  wire logic [psl_pkg::WORD_W-1:0] right_val, // entry of the cell above
    output logic      [psl_pkg::WORD_W-1:0] val,
    output logic                           hit,
    output logic      [psl_pkg::WORD_W-1:0] pick
);

    logic [psl_pkg::WORD_W-1:0] entry_reg;
    logic [psl_pkg::WORD_W-1:0] entry_next;
    logic                       at_pos;
    logic                       above_pos;

    // Position decode against this cell's fixed index
    assign at_pos    = (int'(ctl.pos_idx) == INDEX);
    assign above_pos = (int'(ctl.pos_idx) <  INDEX);

    // Shift / load selection
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins && at_pos) begin
            entry_next = ctl.word;
        end else if (ctl.ins && above_pos) begin
            entry_next = left_val;
        end else if (ctl.del && (at_pos || above_pos)) begin
            entry_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign val  = entry_reg;
    assign hit  = live && (entry_reg == ctl.word);
    assign pick = at_pos ? entry_reg : '0;

endmodule

`default_nettype wire

// ----- src/psl_first.sv -----
`default_nettype none

module psl_first #(
    parameter int N = 64
) (
    input  wire logic [N-1:0]              hit,
    output logic      [psl_pkg::POS_W-1:0] found
);

    // Lowest set hit wins; report it one-based, kept to the field width
    always_comb begin
        found = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = psl_pkg::POS_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/positional_sequential_list_core.sv -----
`default_nettype none

// Bounded ordered list of signed 32-bit words, held in a row of CAPACITY
// cells, one entry per cell. Requests (insert, delete, get, locate, clear)
// arrive as stream beats and each produces exactly one result beat with
// status, the word read, the locate position and the new list length.
// Each request is first registered; then the whole cell row shifts,
// compares and is read in parallel and the result is loaded into the
// output register. The next request is taken while a result still waits
// on m_tready; execution waits only for the output register to free up.
// No clearing pass after reset; entries beyond the length are never read.
module positional_sequential_list_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: func[2:0], position[9:3], item_value[41:10], zero pad[47:42]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // m_tdata: status[0], read_value[32:1], found_position[39:33],
    //          list_length[46:40], zero pad[47]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > psl_pkg::POS_W) ? CW : psl_pkg::POS_W;
    localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

    // Request register
    logic                        req_valid_reg;
    logic [2:0]                  req_func_reg;
    logic [psl_pkg::POS_W-1:0]   req_pos_reg;
    logic [psl_pkg::WORD_W-1:0]  req_word_reg;

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        m_tvalid_reg;
    logic [47:0]                 m_tdata_reg;

    logic                        s_fire;
    logic                        exec;
    logic [PW-1:0]               pos_w;
    logic [PW-1:0]               cnt_w;
    logic                        pos_nz;
    logic                        rd_ok;
    logic                        ins_ok;
    logic                        err;
    logic [psl_pkg::WORD_W-1:0]  rd_word;
    logic [psl_pkg::WORD_W-1:0]  rd_or;
    logic [psl_pkg::POS_W-1:0]   found_any;
    logic [psl_pkg::POS_W-1:0]   found_out;
    psl_pkg::cmd_t               ctl;

    logic [CAPACITY-1:0]         live;
    logic [CAPACITY-1:0]         hit;
    logic [psl_pkg::WORD_W-1:0]  val  [CAPACITY];
    logic [psl_pkg::WORD_W-1:0]  pick [CAPACITY];

    assign s_tready = !req_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign exec     = req_valid_reg && (!m_tvalid_reg || m_tready);

    // Bounds checks against the current length
    assign pos_w  = PW'(req_pos_reg);
    assign cnt_w  = PW'(count_reg);
    assign pos_nz = (req_pos_reg != '0);
    assign rd_ok  = pos_nz && (pos_w <= cnt_w);
    assign ins_ok = pos_nz && (cnt_w < CAP_W) && (pos_w <= cnt_w + PW'(1));

    always_comb begin
        err        = 1'b0;
        count_next = count_reg;
        rd_word    = '0;
        found_out  = '0;
        case (req_func_reg)
            psl_pkg::OP_INSERT: begin
                err = !ins_ok;
                if (ins_ok) count_next = count_reg + CW'(1);
            end
            psl_pkg::OP_DELETE: begin
                err = !rd_ok;
                if (rd_ok) begin
                    count_next = count_reg - CW'(1);
                    rd_word    = rd_or;
                end
            end
            psl_pkg::OP_GET: begin
                err = !rd_ok;
                if (rd_ok) rd_word = rd_or;
            end
            psl_pkg::OP_LOCATE: begin
                found_out = found_any;
            end
            psl_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    // Command broadcast to the cell row
    assign ctl.ins     = exec && (req_func_reg == psl_pkg::OP_INSERT) && ins_ok;
    assign ctl.del     = exec && (req_func_reg == psl_pkg::OP_DELETE) && rd_ok;
    assign ctl.pos_idx = req_pos_reg - psl_pkg::POS_W'(1);
    assign ctl.word    = req_word_reg;

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [psl_pkg::WORD_W-1:0] left_in;
        logic [psl_pkg::WORD_W-1:0] right_in;

        assign live[i] = (CW'(i) < count_reg);

        if (i == 0) begin : g_lo
            assign left_in = '0;
        end else begin : g_lo_n
            assign left_in = val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_hi
            assign right_in = val[i];
        end else begin : g_hi_n
            assign right_in = val[i+1];
        end

        psl_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .live      (live[i]),
            .left_val  (left_in),
            .right_val (right_in),
            .val       (val[i]),
            .hit       (hit[i]),
            .pick      (pick[i])
        );
    end

    // Read gather: at most one cell drives a nonzero pick
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | pick[i];
        end
    end

    psl_first #(
        .N(CAPACITY)
    ) u_first (
        .hit   (hit),
        .found (found_any)
    );

    // Request, length and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                req_valid_reg <= 1'b1;
            end else if (exec) begin
                req_valid_reg <= 1'b0;
            end
            if (exec) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_func_reg <= s_tdata[2:0];
            req_pos_reg  <= s_tdata[9:3];
            req_word_reg <= s_tdata[41:10];
        end
        if (exec) begin
            m_tdata_reg <= {1'b0, psl_pkg::POS_W'(count_next), found_out, rd_word, err};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Length never exceeds the capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("list length above capacity");

    // A successful insert grows the list by one
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    // An error leaves the length alone
    a_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && err) |=> $stable(count_reg))
        else $error("failed request changed the length");

    // Reported length tracks the held length
    a_len_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[46:40] == psl_pkg::POS_W'(count_reg)))
        else $error("reported length differs from held length");

endmodule

`default_nettype wire
